// File: rtl/core/c8pd_pkg.sv
`timescale 1ns / 1ps

package c8pd_pkg;

	// Field widths of the frame format.
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 14;

	// Length byte flag that selects a two-byte length, and the CRC-8 polynomial.
	localparam int unsigned LONG_LEN_BIT = 6;
	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

	// Result kinds.
	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_END     = 1'b1
	} kind_t;

	// One result beat as it travels from the parser through the queue.
	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] payload_byte;
		logic [LEN_W-1:0]  byte_index;
		logic [BYTE_W-1:0] magic_value;
		logic [BYTE_W-1:0] destination_id;
		logic [LEN_W-1:0]  frame_length;
		logic              crc_ok;
	} result_t;

	// Byte-wise CRC-8 update, MSB first, no reflection, no final xor.
	function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = crc ^ b;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/core/c8pd_front.sv
`timescale 1ns / 1ps

module c8pd_front import c8pd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              first_byte,
	output logic              push,
	output result_t           push_data
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_DEST,
		PH_LEN1,
		PH_LEN2,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	phase_t            phase_q;
	logic [BYTE_W-1:0] crc_q;
	logic [LEN_W-1:0]  length_q;
	logic [LEN_W-1:0]  count_q;
	logic [BYTE_W-1:0] magic_q;
	logic [BYTE_W-1:0] dest_q;

	logic [BYTE_W-1:0] crc_next;
	logic [LEN_W-1:0]  count_inc;
	logic [LEN_W-1:0]  short_len;
	logic [LEN_W-1:0]  long_len_hi;

	// CRC step over the current byte and the decoded length forms.
	assign crc_next    = crc8_update(crc_q, data_byte);
	assign count_inc   = count_q + LEN_W'(1);
	assign short_len   = LEN_W'(data_byte);
	assign long_len_hi = {data_byte[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};

	// Classify the beat: payload bytes and checksum bytes produce a result.
	always_comb begin
		push                     = 1'b0;
		push_data.kind           = KIND_PAYLOAD;
		push_data.payload_byte   = data_byte;
		push_data.byte_index     = count_q;
		push_data.magic_value    = magic_q;
		push_data.destination_id = dest_q;
		push_data.frame_length   = length_q;
		push_data.crc_ok         = 1'b0;
		if (accept && !first_byte) begin
			if (phase_q == PH_PAYLOAD) begin
				push = 1'b1;
			end else if (phase_q == PH_CHECK) begin
				push                   = 1'b1;
				push_data.kind         = KIND_END;
				push_data.payload_byte = '0;
				push_data.byte_index   = '0;
				push_data.crc_ok       = (data_byte == crc_q);
			end
		end
	end

	// Frame parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			crc_q    <= '0;
			length_q <= '0;
			count_q  <= '0;
			magic_q  <= '0;
			dest_q   <= '0;
		end else if (accept) begin
			if (first_byte) begin
				magic_q  <= data_byte;
				dest_q   <= '0;
				length_q <= '0;
				count_q  <= '0;
				crc_q    <= crc8_update('0, data_byte);
				phase_q  <= PH_DEST;
			end else begin
				unique case (phase_q)
					PH_DEST: begin
						dest_q  <= data_byte;
						crc_q   <= crc_next;
						phase_q <= PH_LEN1;
					end
					PH_LEN1: begin
						crc_q <= crc_next;
						if (data_byte[LONG_LEN_BIT]) begin
							length_q <= long_len_hi;
							phase_q  <= PH_LEN2;
						end else begin
							length_q <= short_len;
							count_q  <= '0;
							phase_q  <= (short_len == '0) ? PH_CHECK : PH_PAYLOAD;
						end
					end
					PH_LEN2: begin
						crc_q    <= crc_next;
						length_q <= length_q | short_len;
						count_q  <= '0;
						phase_q  <= ((length_q | short_len) == '0) ? PH_CHECK : PH_PAYLOAD;
					end
					PH_PAYLOAD: begin
						crc_q   <= crc_next;
						count_q <= count_inc;
						if (count_inc == length_q) begin
							phase_q <= PH_CHECK;
						end
					end
					PH_CHECK: begin
						phase_q <= PH_IDLE;
					end
					default: begin
						phase_q <= PH_IDLE;
					end
				endcase
			end
		end
	end

	// A result is only produced by an accepted beat.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> accept)
		else $error("result pushed without an accepted beat");

	// The payload phase is never entered with an empty length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (length_q != '0))
		else $error("payload phase with zero length");

	// The payload counter stays below the decoded length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (count_q < length_q))
		else $error("payload counter ran past the length");

endmodule

// File: rtl/core/c8pd_queue.sv
`timescale 1ns / 1ps

module c8pd_queue import c8pd_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    pop,
	output result_t pop_data,
	output logic    empty,
	output logic    full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	result_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == FULL_CNT);
	assign pop_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("queue count above depth");

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from an empty queue");

endmodule

// File: rtl/core/c8pd_back.sv
`timescale 1ns / 1ps

module c8pd_back import c8pd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  result_t q_data,
	output logic    q_pop,
	input  logic    out_stall,
	output logic    out_valid,
	output result_t out_data
);

	logic    valid_q;
	result_t data_q;

	// Load the output register whenever it is empty or its beat is taken.
	assign q_pop     = !q_empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= q_data;
		end
	end

	// A waiting result is not replaced while the receiver stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_stall) |-> !q_pop)
		else $error("output register overwritten while stalled");

	// A pop always leaves a valid beat in the output register.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |=> valid_q)
		else $error("popped result lost");

	// Payload results never carry the CRC pass flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && data_q.kind == KIND_PAYLOAD) |-> !data_q.crc_ok)
		else $error("payload result with crc flag set");

endmodule

// File: rtl/core/crc8_packet_deframer.sv
`timescale 1ns / 1ps

// Packet deframer with CRC-8 check.
// Input channel: one link byte per beat on data_byte, with first_byte high on
// the magic byte of each packet; a beat moves when in_valid is high and
// in_stall is low. A first-flagged byte restarts parsing in any state.
// Output channel: one result per beat when out_valid is high and out_stall is
// low. kind low carries a payload byte with its index; kind high marks the
// end of a packet with the header fields and crc_ok.
// Throughput is one byte per cycle while in_stall is low. A result passes from
// the parser through a result queue of QUEUE_DEPTH entries and the output
// register before it appears on the outputs.
// When the receiver stalls, results collect in the queue; in_stall rises
// only once the queue is full, and is driven from the registered fill count.
// Reset clears the parser to idle, empties the queue and drops out_valid;
// header bytes, stray bytes after a packet and the CRC byte of an abandoned
// packet produce no result.
module crc8_packet_deframer import c8pd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              first_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic [BYTE_W-1:0] payload_byte,
	output logic [LEN_W-1:0]  byte_index,
	output logic [BYTE_W-1:0] magic_value,
	output logic [BYTE_W-1:0] destination_id,
	output logic [LEN_W-1:0]  frame_length,
	output logic              crc_ok
);

	logic    accept;
	logic    push;
	result_t push_data;
	logic    q_pop;
	result_t q_data;
	logic    q_empty;
	logic    q_full;
	result_t out_data;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	c8pd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.push       (push),
		.push_data  (push_data)
	);

	c8pd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty),
		.full      (q_full)
	);

	c8pd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// Unpack the result beat onto its ports.
	assign kind           = out_data.kind;
	assign payload_byte   = out_data.payload_byte;
	assign byte_index     = out_data.byte_index;
	assign magic_value    = out_data.magic_value;
	assign destination_id = out_data.destination_id;
	assign frame_length   = out_data.frame_length;
	assign crc_ok         = out_data.crc_ok;

endmodule
